[design/palette_indexer_pixel_packer_defines.svh]
// Assertion macros for the palette indexer and pixel packer.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PALETTE_INDEXER_PIXEL_PACKER_DEFINES_SVH
`define PALETTE_INDEXER_PIXEL_PACKER_DEFINES_SVH

// Check a condition at every edge outside reset.
`define PIPP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another one at the next edge.
`define PIPP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[design/pipp_pkg.sv]
// Shared types, register indexes and mode decode for the palette indexer.
// No dependencies.
package pipp_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int KEY_W       = 15;
  localparam int IDX_W       = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_BITS_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_USED      = 2'd1;

  localparam logic [1:0] MODE_BITS2 = 2'd0;
  localparam logic [1:0] MODE_BITS4 = 2'd1;
  localparam logic [1:0] MODE_BITS8 = 2'd2;

  localparam logic [IDX_W-1:0] TRANSPARENT_IDX = 8'hff;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       final_pixel;
  } pipp_pixel_t;

  typedef struct packed {
    logic [7:0]  packed_byte;
    logic        byte_ready;
    logic [7:0]  pixel_index;
    logic        index_valid;
    logic        new_entry;
    logic [15:0] entry_color;
    logic [7:0]  palette_size;
    logic        too_many_colors;
    logic        image_done;
  } pipp_result_t;

  // Search token walking down the palette cells.
  typedef struct packed {
    logic             valid;
    logic             append_ok;
    logic             found;
    logic             added;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] remain;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] idx;
  } pipp_probe_t;

  function automatic logic [7:0] index_mask(input logic [1:0] mode);
    logic [7:0] m;
    unique case (mode)
      MODE_BITS2: m = 8'h03;
      MODE_BITS4: m = 8'h0f;
      default:    m = 8'hff;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] last_slot(input logic [1:0] mode);
    logic [1:0] s;
    unique case (mode)
      MODE_BITS2: s = 2'd3;
      MODE_BITS4: s = 2'd1;
      default:    s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

[design/palette_indexer_pixel_packer.sv]
// Palette indexer and packer for RGB555 indexed pixels.
// Input beat: one RGBA pixel on in_data (in_valid/in_stall). Output beat: one
// result per pixel on out_data (out_valid/out_stall). Configuration beats on
// cfg_valid/cfg_ready (always ready) set the index width and the alpha test;
// write them only while the block is idle.
// An opaque pixel's key walks down a row of PALETTE_DEPTH cells, one cell per
// cycle; each cell compares against its entry or takes the key as a new entry.
// An opaque pixel passes the launch register, the cells and the finish stage
// into the output register; a transparent one goes straight to the finish
// stage. A new pixel is taken only when idle again after its predecessor's
// result is loaded, so the time per pixel is set by the length of the cell row.
// Reset clears the palette fill, packer, overflow flag and registers to their
// defaults; no clearing pass is needed, since only filled cells are compared.
// When the receiver stalls, the result holds in the output register and the
// next pixel is still accepted; its result waits in the finish stage until the
// output register frees up.
`include "palette_indexer_pixel_packer_defines.svh"
module palette_indexer_pixel_packer
  import pipp_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pipp_pixel_t            in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output pipp_result_t           out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_FINISH} state_t;

  state_t           state_r;
  logic [1:0]       mode_r;
  logic             alpha_used_r;
  logic [IDX_W-1:0] fill_r;
  logic [7:0]       accum_r;
  logic [1:0]       slot_r;
  logic             overflow_r;
  logic [15:0]      color_r;
  logic             last_r;
  logic             pend_found_r;
  logic             pend_added_r;
  logic [IDX_W-1:0] pend_idx_r;
  pipp_probe_t      launch_r;
  logic             out_valid_r;
  pipp_result_t     out_r;

  pipp_probe_t link [PALETTE_DEPTH+1];

  assign link[0] = launch_r;

  for (genvar gi = 0; gi < PALETTE_DEPTH; gi++) begin : g_cell
    pipp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .probe_in (link[gi]),
      .probe_out(link[gi+1])
    );
  end

  pipp_probe_t tail;
  assign tail = link[PALETTE_DEPTH];

  logic             in_beat;
  logic             transparent;
  logic [8:0]       mask9;
  logic [8:0]       cap;
  pipp_probe_t      probe_nxt;
  logic [15:0]      color_nxt;
  logic             fin_go;
  logic [7:0]       mask;
  logic [1:0]       lslot;
  logic [1:0]       eslot;
  logic [2:0]       sh;
  logic [7:0]       idx_m;
  logic [7:0]       accum_new;
  logic [7:0]       accum_nxt;
  logic [1:0]       slot_nxt;
  logic             ready;
  logic [7:0]       byte_out;
  logic [IDX_W-1:0] fill_nxt;
  logic             overflow_nxt;
  pipp_result_t     res;

  assign in_stall  = state_r != ST_IDLE;
  assign in_beat   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign fin_go    = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  always_comb begin
    transparent = alpha_used_r && !in_data.alpha[7];
    mask9       = {1'b0, index_mask(mode_r)};
    cap         = (mask9 < 9'(PALETTE_DEPTH)) ? mask9 : 9'(PALETTE_DEPTH);
    color_nxt   = {in_data.red[7:3], in_data.green[7:3], 1'b0, in_data.blue[7:3]};
    probe_nxt.valid     = in_beat && !transparent;
    probe_nxt.append_ok = {1'b0, fill_r} < cap;
    probe_nxt.found     = 1'b0;
    probe_nxt.added     = 1'b0;
    probe_nxt.key       = {in_data.red[7:3], in_data.green[7:3], in_data.blue[7:3]};
    probe_nxt.remain    = fill_r;
    probe_nxt.pos       = '0;
    probe_nxt.idx       = '0;
  end

  always_comb begin
    mask  = index_mask(mode_r);
    lslot = last_slot(mode_r);
    idx_m = pend_idx_r & mask;
    eslot = slot_r & lslot;
    unique case (mode_r)
      MODE_BITS2: sh = {2'd3 - eslot, 1'b0};
      MODE_BITS4: sh = {~eslot[0], 2'b00};
      default:    sh = 3'd0;
    endcase
    accum_new = accum_r | 8'(idx_m << sh);
    accum_nxt = accum_r;
    slot_nxt  = slot_r;
    ready     = 1'b0;
    byte_out  = 8'h00;
    if (pend_found_r) begin
      if (eslot == lslot) begin
        byte_out  = accum_new;
        ready     = 1'b1;
        accum_nxt = 8'h00;
        slot_nxt  = 2'd0;
      end else begin
        accum_nxt = accum_new;
        slot_nxt  = eslot + 2'd1;
      end
    end
    if (last_r && !ready && (slot_nxt != 2'd0)) begin
      byte_out = accum_nxt;
      ready    = 1'b1;
    end
    fill_nxt     = fill_r + IDX_W'(pend_added_r);
    overflow_nxt = overflow_r | !pend_found_r;
    res.packed_byte     = byte_out;
    res.byte_ready      = ready;
    res.pixel_index     = pend_found_r ? idx_m : 8'h00;
    res.index_valid     = pend_found_r;
    res.new_entry       = pend_added_r;
    res.entry_color     = color_r;
    res.palette_size    = fill_nxt;
    res.too_many_colors = overflow_nxt;
    res.image_done      = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      mode_r         <= MODE_BITS8;
      alpha_used_r   <= 1'b0;
      fill_r         <= '0;
      accum_r        <= 8'h00;
      slot_r         <= 2'd0;
      overflow_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      launch_r.valid <= 1'b0;
    end else begin
      launch_r    <= probe_nxt;
      out_valid_r <= fin_go || (out_valid_r && out_stall);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PIXEL_BITS_MODE: mode_r       <= cfg_data[1:0];
          CFG_ALPHA_USED:      alpha_used_r <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            color_r      <= color_nxt;
            last_r       <= in_data.final_pixel;
            pend_found_r <= 1'b1;
            pend_added_r <= 1'b0;
            pend_idx_r   <= TRANSPARENT_IDX;
            if (transparent) begin
              state_r <= ST_FINISH;
            end else begin
              state_r <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (tail.valid) begin
            pend_found_r <= tail.found;
            pend_added_r <= tail.added;
            pend_idx_r   <= tail.idx;
            state_r      <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (fin_go) begin
            out_r   <= res;
            state_r <= ST_IDLE;
            if (last_r) begin
              fill_r     <= '0;
              accum_r    <= 8'h00;
              slot_r     <= 2'd0;
              overflow_r <= 1'b0;
            end else begin
              fill_r     <= fill_nxt;
              accum_r    <= accum_nxt;
              slot_r     <= slot_nxt;
              overflow_r <= overflow_nxt;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `PIPP_ASSERT_NEXT(a_accept_leaves_idle, in_beat, state_r != ST_IDLE, "pixel accepted but block stayed idle")
  `PIPP_ASSERT(a_tail_in_search, !tail.valid || (state_r == ST_SEARCH), "search token left the row outside search")
  `PIPP_ASSERT(a_fill_bound, {1'b0, fill_r} <= 9'(PALETTE_DEPTH), "palette fill beyond depth")
  `PIPP_ASSERT(a_drop_no_entry, !out_valid_r || out_r.index_valid || !out_r.new_entry, "dropped pixel marked as new entry")
  `PIPP_ASSERT_NEXT(a_finish_loads, fin_go, out_valid_r && (state_r == ST_IDLE), "finished result not loaded")

endmodule

[design/pipp_cell.sv]
// One palette cell: holds one entry and passes the search token on.
// Depends on pipp_pkg.
module pipp_cell
  import pipp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  pipp_probe_t probe_in,
  output pipp_probe_t probe_out
);

  logic [KEY_W-1:0] entry_r;
  pipp_probe_t      probe_r;
  pipp_probe_t      probe_nxt;
  logic             occupied;
  logic             hit;
  logic             ins;

  always_comb begin
    occupied  = probe_in.remain != '0;
    hit       = probe_in.valid && !probe_in.found && occupied && (entry_r == probe_in.key);
    ins       = probe_in.valid && !probe_in.found && !occupied && probe_in.append_ok;
    probe_nxt = probe_in;
    probe_nxt.found  = probe_in.found | hit | ins;
    probe_nxt.added  = probe_in.added | ins;
    probe_nxt.idx    = (hit || ins) ? probe_in.pos : probe_in.idx;
    probe_nxt.remain = occupied ? probe_in.remain - 1'b1 : '0;
    probe_nxt.pos    = probe_in.pos + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      entry_r <= probe_in.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.valid <= 1'b0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  assign probe_out = probe_r;

endmodule
